>>> hw/rtl/nwps_pkg.sv
// Package for the nearest waypoint proximity search block.
// Holds widths, coordinate and payload types, operation codes and helpers.
// No dependencies.
package nwps_pkg;

    localparam int CameraDepth = 1024;
    localparam int UserDepth   = 128;
    localparam int MatchLimit  = 4;
    localparam int CamAw       = $clog2(CameraDepth);
    localparam int UserAw      = $clog2(UserDepth);
    localparam int MatchW      = $clog2(MatchLimit + 1);
    localparam int EntryW      = 48;

    localparam logic [15:0] MinutesWrap = 16'd60000;
    localparam logic [15:0] NearLimit   = 16'd500;
    localparam logic [15:0] Class1Limit = 16'd500;
    localparam logic [15:0] Class2Limit = 16'd5625;
    localparam logic [15:0] Class3Limit = 16'd15625;

    typedef enum logic [1:0] {
        OP_LOAD_CAMERA = 2'd0,
        OP_LOAD_USER   = 2'd1,
        OP_QUERY       = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_CAMERA_COUNT = 2'd0,
        REG_USER_COUNT   = 2'd1,
        REG_USER_VALID   = 2'd2,
        REG_NONE         = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  entry_index;
        logic [6:0]  north_degree;
        logic [15:0] north_milliminute;
        logic [7:0]  east_degree;
        logic [15:0] east_milliminute;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  distance_class;
        logic        target_is_user;
        logic [14:0] squared_length;
        logic [9:0]  camera_slot;
    } out_item_t;

    // Stored table entry: north degree padded to 8 bits.
    typedef struct packed {
        logic [7:0]  n_deg;
        logic [15:0] n_mm;
        logic [7:0]  e_deg;
        logic [15:0] e_mm;
    } entry_t;

    // Datapath commands, issued by the controller.
    typedef struct packed {
        logic              cap_pos;     // latch the query position
        logic              cam_rd;      // read camera memory
        logic [CamAw-1:0]  cam_addr;
        logic              user_rd;     // read user memory
        logic [UserAw-1:0] user_addr;
        logic              cmp_north;   // evaluate north ordering of camera read data
        logic              cap_top;     // store camera read data as top entry
        logic              cap_bot;     // store camera read data as bottom entry
        logic              cam_eval;    // evaluate camera read data for a match
        logic              user_eval;   // evaluate user read data
        logic              clr_result;  // clear the per-query result
        logic              finish;      // produce the result
    } dp_cmd_t;

    // Datapath status, back to the controller.
    typedef struct packed {
        logic [1:0] north_cmp;   // 0 equal, 1 entry greater, 2 entry less
        logic       top_closer;  // top entry not farther than bottom
        logic       north_near;  // last camera read is near in north
        logic       user_hit;
        logic [MatchW-1:0] kept;
    } dp_stat_t;

    localparam logic [1:0] CmpEq = 2'd0;
    localparam logic [1:0] CmpGt = 2'd1;
    localparam logic [1:0] CmpLt = 2'd2;

    // Interval between two coordinates on one axis.
    function automatic logic [23:0] gap(input logic [7:0] ad, input logic [15:0] am,
                                        input logic [7:0] bd, input logic [15:0] bm);
        logic [7:0]  dd;
        logic [15:0] dm;
        dd = 8'd0;
        dm = 16'd0;
        if (ad > bd)
        begin
            if (am >= bm)
            begin
                dd = ad - bd;
                dm = am - bm;
            end
            else
            begin
                dd = ad - bd - 8'd1;
                dm = MinutesWrap - (bm - am);
            end
        end
        else if (ad < bd)
        begin
            if (am <= bm)
            begin
                dd = bd - ad;
                dm = bm - am;
            end
            else
            begin
                dd = bd - ad - 8'd1;
                dm = MinutesWrap - (am - bm);
            end
        end
        else
        begin
            dm = (am >= bm) ? am - bm : bm - am;
        end
        return {dd, dm};
    endfunction

    function automatic logic near_axis(input logic [7:0] ad, input logic [15:0] am,
                                       input logic [7:0] bd, input logic [15:0] bm);
        logic [23:0] g;
        g = gap(ad, am, bd, bm);
        return (g[23:16] == 8'd0) && (g[15:0] < NearLimit);
    endfunction

    function automatic logic [1:0] label(input logic [15:0] len);
        logic [1:0] c;
        if (len < Class1Limit)
            c = 2'd1;
        else if (len < Class2Limit)
            c = 2'd2;
        else if (len < Class3Limit)
            c = 2'd3;
        else
            c = 2'd0;
        return c;
    endfunction

endpackage

>>> hw/rtl/nearest_waypoint_proximity_search.sv
// Nearest waypoint proximity search. A load transfer gives no result and leaves busy low,
// so loads can follow back to back. A query holds busy from the cycle after its transfer
// through its result cycle, stepping through the binary search, a pick between two bracketing
// slots, a check of the hit, neighbor probes each side, the camera and user scans, drain,
// finish and result.
// Reset clears the control registers and the user-chosen flag; the tables are undefined; no stall.
module nearest_waypoint_proximity_search (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  nwps_pkg::in_item_t  item,
    output logic                res_valid,
    output nwps_pkg::out_item_t res,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [10:0]         cfg_data
);
    import nwps_pkg::*;

    logic [10:0] camera_count_reg;
    logic [7:0]  user_count_reg;
    logic        user_valid_reg;
    logic        accept;
    logic        go;
    logic        done;
    logic        ctrl_busy;
    logic        res_valid_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    // Transfer happens when start is seen while idle.
    assign accept = start && !busy;
    assign go     = accept && (item.operation == OP_QUERY);
    // Hold busy through the cycle the result is shown.
    assign busy   = ctrl_busy || res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_count_reg <= '0;
            user_count_reg   <= '0;
            user_valid_reg   <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            res_valid_reg <= done;
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_CAMERA_COUNT: camera_count_reg <= cfg_data;
                    REG_USER_COUNT:   user_count_reg   <= cfg_data[7:0];
                    REG_USER_VALID:   user_valid_reg   <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    nwps_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .camera_count (camera_count_reg),
        .user_count   (user_count_reg),
        .user_valid   (user_valid_reg),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (ctrl_busy),
        .done         (done)
    );

    // Drop loads whose slot is beyond the table.
    nwps_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_cam  (accept && item.operation == OP_LOAD_CAMERA &&
                    ({1'b0, item.entry_index} < 11'(CameraDepth))),
        .load_user (accept && item.operation == OP_LOAD_USER &&
                    ({1'b0, item.entry_index} < 11'(UserDepth))),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res)
    );

    assign res_valid = res_valid_reg;
endmodule

>>> hw/rtl/nwps_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module nwps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/nwps_datapath.sv
// Datapath: table memories, distance arithmetic and result registers.
// Depends on nwps_pkg and nwps_ram.
module nwps_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_cam,
    input  logic                load_user,
    input  nwps_pkg::in_item_t  item,
    input  nwps_pkg::dp_cmd_t   cmd,
    output nwps_pkg::dp_stat_t  stat,
    output nwps_pkg::out_item_t res
);
    import nwps_pkg::*;

    entry_t            item_e;
    entry_t            cam_q;
    entry_t            user_q;
    logic [CamAw-1:0]  cam_waddr;
    logic [UserAw-1:0] user_waddr;
    logic [EntryW-1:0] cam_rdata;
    logic [EntryW-1:0] user_rdata;

    entry_t            pos_reg;
    logic [23:0]       top_gap_reg;
    logic [23:0]       bot_gap_reg;
    logic [CamAw-1:0]  rd_addr_reg;
    logic [CamAw-1:0]  cam_slot_reg;
    logic [15:0]       cam_len_reg;
    logic              cam_hit_reg;
    logic [MatchW-1:0] kept_reg;
    logic              user_hit_reg;
    logic [15:0]       user_len_reg;
    logic              flag_reg;
    logic              flag_next;
    out_item_t         res_reg;
    out_item_t         res_next;

    // Squared-length pipeline: square terms registered, then summed.
    logic [13:0]       dn_q;
    logic [13:0]       de_q;
    logic [27:0]       sqn_reg;
    logic [27:0]       sqe_reg;
    logic              sq_cam_reg;
    logic              sq_user_reg;
    logic [CamAw-1:0]  sq_addr_reg;
    logic [15:0]       sq_len;
    logic [23:0]       gn;
    logic [23:0]       ge;

    assign item_e     = '{n_deg: {1'b0, item.north_degree}, n_mm: item.north_milliminute,
                          e_deg: item.east_degree, e_mm: item.east_milliminute};
    assign cam_waddr  = item.entry_index[CamAw-1:0];
    assign user_waddr = item.entry_index[UserAw-1:0];

    nwps_ram #(.WIDTH(EntryW), .DEPTH(CameraDepth)) u_cam_ram (
        .clk   (clk),
        .we    (load_cam),
        .waddr (cam_waddr),
        .wdata (item_e),
        .re    (cmd.cam_rd),
        .raddr (cmd.cam_addr),
        .rdata (cam_rdata)
    );

    nwps_ram #(.WIDTH(EntryW), .DEPTH(UserDepth)) u_user_ram (
        .clk   (clk),
        .we    (load_user),
        .waddr (user_waddr),
        .wdata (item_e),
        .re    (cmd.user_rd),
        .raddr (cmd.user_addr),
        .rdata (user_rdata)
    );

    assign cam_q  = cam_rdata;
    assign user_q = user_rdata;

    always_comb
    begin
        if (cam_q.n_deg != pos_reg.n_deg)
            stat.north_cmp = (cam_q.n_deg > pos_reg.n_deg) ? CmpGt : CmpLt;
        else if (cam_q.n_mm != pos_reg.n_mm)
            stat.north_cmp = (cam_q.n_mm > pos_reg.n_mm) ? CmpGt : CmpLt;
        else
            stat.north_cmp = CmpEq;
    end

    assign stat.top_closer = !((top_gap_reg[23:16] > bot_gap_reg[23:16]) ||
                               ((top_gap_reg[23:16] == bot_gap_reg[23:16]) &&
                                (top_gap_reg[15:0] > bot_gap_reg[15:0])));
    assign stat.north_near = near_axis(cam_q.n_deg, cam_q.n_mm, pos_reg.n_deg, pos_reg.n_mm);
    assign stat.user_hit   = user_hit_reg;
    assign stat.kept       = kept_reg;

    // Gap of whichever table is being evaluated this cycle.
    always_comb
    begin
        if (cmd.user_eval)
        begin
            gn = gap(user_q.n_deg, user_q.n_mm, pos_reg.n_deg, pos_reg.n_mm);
            ge = gap(user_q.e_deg, user_q.e_mm, pos_reg.e_deg, pos_reg.e_mm);
        end
        else
        begin
            gn = gap(cam_q.n_deg, cam_q.n_mm, pos_reg.n_deg, pos_reg.n_mm);
            ge = gap(cam_q.e_deg, cam_q.e_mm, pos_reg.e_deg, pos_reg.e_mm);
        end
    end

    assign dn_q   = gn[15:2];
    assign de_q   = ge[15:2];
    assign sq_len = sqn_reg[15:0] + sqe_reg[15:0];

    always_comb
    begin
        flag_next = flag_reg;
        res_next  = res_reg;
        if (cmd.finish)
        begin
            res_next = '0;
            res_next.camera_slot = cam_slot_reg[9:0];
            if (cam_hit_reg)
            begin
                if (user_hit_reg && (cam_len_reg > user_len_reg))
                begin
                    res_next.squared_length = user_len_reg[14:0];
                    res_next.distance_class = label(user_len_reg);
                    flag_next = 1'b1;
                end
                else
                begin
                    res_next.squared_length = cam_len_reg[14:0];
                    res_next.distance_class = label(cam_len_reg);
                    flag_next = 1'b0;
                end
            end
            else if (user_hit_reg)
            begin
                res_next.squared_length = user_len_reg[14:0];
                res_next.distance_class = label(user_len_reg);
                flag_next = 1'b1;
            end
            res_next.target_is_user = flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg     <= 1'b0;
            cam_hit_reg  <= 1'b0;
            user_hit_reg <= 1'b0;
            kept_reg     <= '0;
            sq_cam_reg   <= 1'b0;
            sq_user_reg  <= 1'b0;
        end
        else
        begin
            flag_reg    <= flag_next;
            sq_cam_reg  <= 1'b0;
            sq_user_reg <= 1'b0;
            if (cmd.clr_result)
            begin
                cam_hit_reg  <= 1'b0;
                user_hit_reg <= 1'b0;
                kept_reg     <= '0;
            end
            // Camera match in range on both axes, below the match limit: count and square.
            if (cmd.cam_eval && stat.north_near &&
                near_axis(cam_q.e_deg, cam_q.e_mm, pos_reg.e_deg, pos_reg.e_mm) &&
                (kept_reg < MatchW'(MatchLimit)))
            begin
                kept_reg   <= kept_reg + MatchW'(1);
                sq_cam_reg <= 1'b1;
            end
            if (cmd.user_eval && !user_hit_reg &&
                near_axis(user_q.n_deg, user_q.n_mm, pos_reg.n_deg, pos_reg.n_mm) &&
                near_axis(user_q.e_deg, user_q.e_mm, pos_reg.e_deg, pos_reg.e_mm))
            begin
                user_hit_reg <= 1'b1;
                sq_user_reg  <= 1'b1;
            end
            if (sq_cam_reg)
                cam_hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_pos)
            pos_reg <= item_e;
        if (cmd.cap_top)
            top_gap_reg <= gap(cam_q.n_deg, cam_q.n_mm, pos_reg.n_deg, pos_reg.n_mm);
        if (cmd.cap_bot)
            bot_gap_reg <= gap(cam_q.n_deg, cam_q.n_mm, pos_reg.n_deg, pos_reg.n_mm);
        if (cmd.cam_rd)
            rd_addr_reg <= cmd.cam_addr;
        sqn_reg     <= dn_q * dn_q;
        sqe_reg     <= de_q * de_q;
        sq_addr_reg <= rd_addr_reg;
        if (cmd.clr_result)
            cam_slot_reg <= '0;
        if (sq_cam_reg && (!cam_hit_reg || (sq_len < cam_len_reg)))
        begin
            cam_len_reg  <= sq_len;
            cam_slot_reg <= sq_addr_reg;
        end
        if (sq_user_reg)
            user_len_reg <= sq_len;
        res_reg <= res_next;
    end

    assign res = res_reg;
endmodule

>>> hw/rtl/nwps_controller.sv
// Controller: sequences binary search, widening, camera scan and user scan.
// Depends on nwps_pkg.
module nwps_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [10:0]          camera_count,
    input  logic [7:0]           user_count,
    input  logic                 user_valid,
    input  nwps_pkg::dp_stat_t   stat,
    output nwps_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import nwps_pkg::*;

    localparam int CntW = CamAw + 1;
    localparam int UCntW = UserAw + 1;

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000000000000001,
        S_BS_RD  = 16'b0000000000000010,
        S_BS_CHK = 16'b0000000000000100,
        S_TB_RD  = 16'b0000000000001000,
        S_TB_CHK = 16'b0000000000010000,
        S_PICK   = 16'b0000000000100000,
        S_KEY_RD = 16'b0000000001000000,
        S_KEY_CHK= 16'b0000000010000000,
        S_HI_RD  = 16'b0000000100000000,
        S_HI_CHK = 16'b0000001000000000,
        S_LO_RD  = 16'b0000010000000000,
        S_LO_CHK = 16'b0000100000000000,
        S_SCAN   = 16'b0001000000000000,
        S_USER   = 16'b0010000000000000,
        S_DRAIN  = 16'b0100000000000000,
        S_DONE   = 16'b1000000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CamAw-1:0]  top_reg, top_next;
    logic [CamAw-1:0]  bot_reg, bot_next;
    logic [CamAw-1:0]  key_reg, key_next;
    logic [CamAw-1:0]  hi_reg, hi_next;
    logic [CamAw-1:0]  lo_reg, lo_next;
    logic [CntW-1:0]   scan_reg, scan_next;   // next camera address to read
    logic [UCntW-1:0]  uidx_reg, uidx_next;
    logic [2:0]        drain_reg, drain_next;
    logic [CntW-1:0]   ncam;
    logic [UCntW-1:0]  nuser;
    logic [CamAw-1:0]  mid;
    logic [CamAw:0]    mid_sum;
    logic              scan_rd;
    logic              scan_reg_v, scan_v_next;

    assign ncam  = (camera_count > 11'(CameraDepth)) ? CntW'(CameraDepth) : CntW'(camera_count);
    assign nuser = (user_count > 8'(UserDepth)) ? UCntW'(UserDepth) : UCntW'(user_count);
    assign mid_sum = {1'b0, top_reg} + {1'b0, bot_reg};
    assign mid     = mid_sum[CamAw:1];
    assign busy    = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        top_next    = top_reg;
        bot_next    = bot_reg;
        key_next    = key_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        scan_next   = scan_reg;
        uidx_next   = uidx_reg;
        drain_next  = drain_reg;
        scan_v_next = 1'b0;
        scan_rd     = 1'b0;
        cmd         = '0;
        done        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    cmd.cap_pos    = 1'b1;
                    cmd.clr_result = 1'b1;
                    top_next = '0;
                    bot_next = CamAw'(ncam - CntW'(1));
                    if (ncam != '0)
                        state_next = S_BS_RD;
                    else
                        state_next = S_USER;
                    uidx_next = '0;
                end
            end
            S_BS_RD:
            begin
                cmd.cam_rd   = 1'b1;
                cmd.cam_addr = mid;
                key_next     = mid;
                state_next   = S_BS_CHK;
            end
            S_BS_CHK:
            begin
                if (stat.north_cmp == CmpEq)
                    state_next = S_KEY_RD;
                else
                begin
                    if (stat.north_cmp == CmpGt)
                        bot_next = key_reg;
                    else
                        top_next = key_reg;
                    if (((stat.north_cmp == CmpGt) ? key_reg - top_reg : bot_reg - key_reg)
                        <= CamAw'(1))
                    begin
                        cmd.cam_rd   = 1'b1;
                        cmd.cam_addr = (stat.north_cmp == CmpGt) ? top_reg : key_reg;
                        state_next   = S_TB_RD;
                    end
                    else
                        state_next = S_BS_RD;
                end
            end
            S_TB_RD:
            begin
                cmd.cap_top  = 1'b1;
                cmd.cam_rd   = 1'b1;
                cmd.cam_addr = bot_reg;
                state_next   = S_TB_CHK;
            end
            S_TB_CHK:
            begin
                cmd.cap_bot = 1'b1;
                state_next  = S_PICK;
            end
            S_PICK:
            begin
                // Take the nearer bracket, the lower slot on a tie.
                key_next   = stat.top_closer ? top_reg : bot_reg;
                state_next = S_KEY_RD;
            end
            S_KEY_RD:
            begin
                cmd.cam_rd   = 1'b1;
                cmd.cam_addr = key_reg;
                state_next   = S_KEY_CHK;
            end
            S_KEY_CHK:
            begin
                if (stat.north_near)
                begin
                    hi_next = key_reg;
                    lo_next = key_reg;
                    state_next = S_HI_RD;
                end
                else
                    state_next = S_USER;
            end
            S_HI_RD:
            begin
                if (CntW'(hi_reg) + CntW'(1) < ncam)
                begin
                    cmd.cam_rd   = 1'b1;
                    cmd.cam_addr = hi_reg + CamAw'(1);
                    state_next   = S_HI_CHK;
                end
                else
                    state_next = S_LO_RD;
            end
            S_HI_CHK:
            begin
                if (stat.north_near)
                begin
                    hi_next    = hi_reg + CamAw'(1);
                    state_next = S_HI_RD;
                end
                else
                    state_next = S_LO_RD;
            end
            S_LO_RD:
            begin
                if (lo_reg != '0)
                begin
                    cmd.cam_rd   = 1'b1;
                    cmd.cam_addr = lo_reg - CamAw'(1);
                    state_next   = S_LO_CHK;
                end
                else
                begin
                    scan_next  = CntW'(lo_reg);
                    state_next = S_SCAN;
                end
            end
            S_LO_CHK:
            begin
                if (stat.north_near)
                begin
                    lo_next    = lo_reg - CamAw'(1);
                    state_next = S_LO_RD;
                end
                else
                begin
                    scan_next  = CntW'(lo_reg);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Read one entry a cycle while in range and under the match limit; evaluate the one read last cycle.
                cmd.cam_eval = scan_reg_v;
                if (scan_reg <= CntW'(hi_reg) && stat.kept < MatchW'(MatchLimit))
                begin
                    scan_rd      = 1'b1;
                    cmd.cam_rd   = 1'b1;
                    cmd.cam_addr = scan_reg[CamAw-1:0];
                    scan_next    = scan_reg + CntW'(1);
                    scan_v_next  = 1'b1;
                end
                else if (!scan_reg_v)
                begin
                    uidx_next  = '0;
                    state_next = S_USER;
                end
            end
            S_USER:
            begin
                cmd.user_eval = scan_reg_v;
                if (user_valid && uidx_reg < nuser && !stat.user_hit)
                begin
                    cmd.user_rd   = 1'b1;
                    cmd.user_addr = uidx_reg[UserAw-1:0];
                    uidx_next     = uidx_reg + UCntW'(1);
                    scan_v_next   = 1'b1;
                end
                else if (!scan_reg_v)
                begin
                    drain_next = 3'd3;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg - 3'd1;
                if (drain_reg == 3'd1)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            top_reg    <= '0;
            bot_reg    <= '0;
            key_reg    <= '0;
            hi_reg     <= '0;
            lo_reg     <= '0;
            scan_reg   <= '0;
            uidx_reg   <= '0;
            drain_reg  <= '0;
            scan_reg_v <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            top_reg    <= top_next;
            bot_reg    <= bot_next;
            key_reg    <= key_next;
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
            scan_reg   <= scan_next;
            uidx_reg   <= uidx_next;
            drain_reg  <= drain_next;
            scan_reg_v <= scan_v_next & (scan_rd | cmd.user_rd);
        end
    end
endmodule

>>> hw/rtl/nwps_checker.sv
// Port-level checker for the proximity search block, bound to the top level.
// Depends on nwps_pkg.
module nwps_port_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input nwps_pkg::out_item_t res,
    input logic                res_valid
);
    import nwps_pkg::*;

    a_busy_at_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> busy)
        else $error("result shown while not busy");
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !res_valid)
        else $error("result strobe longer than one cycle");
    a_no_result_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !res_valid)
        else $error("result right after a transfer");
    a_class_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.distance_class == 2'd1) |-> (res.squared_length < 15'd500))
        else $error("class one with long length");
    a_class_two_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.distance_class == 2'd2) |->
        ((res.squared_length >= 15'd500) && (res.squared_length < 15'd5625)))
        else $error("class two outside its band");
endmodule

bind nearest_waypoint_proximity_search nwps_port_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .res       (res),
    .res_valid (res_valid)
);
